// ===== src/host_power_button_sequencer_defines.svh =====
// Assertion macros shared by the checker of the host power button sequencer.
// No dependencies; include by bare file name.
`ifndef HOST_POWER_BUTTON_SEQUENCER_DEFINES_SVH
`define HOST_POWER_BUTTON_SEQUENCER_DEFINES_SVH

// Same-cycle implication, masked while reset is low.
`define HPBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpbs check failed");

// Next-cycle implication, masked while reset is low.
`define HPBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpbs check failed");

// Next-cycle implication that also watches the reset itself.
`define HPBS_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hpbs reset check failed");

`endif

// ===== src/hpbs_pkg.sv =====
// Types and constants of the host power button sequencer.
// No dependencies; imported by every module of the block.
package hpbs_pkg;

    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 3;

    // Request kinds on the input channel
    localparam logic [1:0] REQ_TICK      = 2'd0;
    localparam logic [1:0] REQ_EDGE      = 2'd1;
    localparam logic [1:0] REQ_HEARTBEAT = 2'd2;
    localparam logic [1:0] REQ_HALT      = 2'd3;

    // Host state codes as reported
    localparam logic [1:0] HOST_OFF     = 2'd0;
    localparam logic [1:0] HOST_ON      = 2'd1;
    localparam logic [1:0] HOST_PENDING = 2'd2;
    localparam logic [1:0] HOST_HALTING = 2'd3;

    // Pulse requests
    localparam logic [1:0] PULSE_NONE  = 2'd0;
    localparam logic [1:0] PULSE_WAKE  = 2'd1;
    localparam logic [1:0] PULSE_RESET = 2'd2;

    // Press classification
    localparam logic [1:0] PRESS_NONE    = 2'd0;
    localparam logic [1:0] PRESS_CLICK   = 2'd1;
    localparam logic [1:0] PRESS_LONG    = 2'd2;
    localparam logic [1:0] PRESS_IGNORED = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CLICK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CLICK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TMO     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEND_TMO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALT_TMO   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIVE_USED = 3'd6;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] RST_MIN_CLICK  = 20'd120;
    localparam logic [CFG_W-1:0] RST_MAX_CLICK  = 20'd2000;
    localparam logic [CFG_W-1:0] RST_LONG_PRESS = 20'd5000;
    localparam logic [CFG_W-1:0] RST_ON_TMO     = 20'd30000;
    localparam logic [CFG_W-1:0] RST_PEND_TMO   = 20'd60000;
    localparam logic [CFG_W-1:0] RST_HALT_TMO   = 20'd10000;

    typedef enum logic [3:0] {
        MODE_OFF     = 4'b0001,
        MODE_ON      = 4'b0010,
        MODE_PENDING = 4'b0100,
        MODE_HALTING = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [CFG_W-1:0] min_click_ms;
        logic [CFG_W-1:0] max_click_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] on_timeout_ms;
        logic [CFG_W-1:0] pending_timeout_ms;
        logic [CFG_W-1:0] halting_timeout_ms;
        logic             alive_pin_used;
    } t_cfg;

    typedef struct packed {
        logic [1:0] host_state;
        logic [1:0] pulse_action;
        logic       shutdown_msg;
        logic       sleep_request;
        logic [1:0] press_class;
    } t_result;

    function automatic logic [1:0] mode_code(input t_mode mode);
        logic [1:0] code;
        case (mode)
            MODE_ON:      code = HOST_ON;
            MODE_PENDING: code = HOST_PENDING;
            MODE_HALTING: code = HOST_HALTING;
            default:      code = HOST_OFF;
        endcase
        return code;
    endfunction

endpackage

// ===== src/hpbs_cfg.sv =====
// Configuration register file of the host power button sequencer.
// Depends on hpbs_pkg.
module hpbs_cfg
    import hpbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_cfg_ready,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_CLICK:  n_cfg.min_click_ms       = i_cfg_data;
                CFG_MAX_CLICK:  n_cfg.max_click_ms       = i_cfg_data;
                CFG_LONG_PRESS: n_cfg.long_press_ms      = i_cfg_data;
                CFG_ON_TMO:     n_cfg.on_timeout_ms      = i_cfg_data;
                CFG_PEND_TMO:   n_cfg.pending_timeout_ms = i_cfg_data;
                CFG_HALT_TMO:   n_cfg.halting_timeout_ms = i_cfg_data;
                CFG_ALIVE_USED: n_cfg.alive_pin_used     = i_cfg_data[0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_click_ms       <= RST_MIN_CLICK;
            r_cfg.max_click_ms       <= RST_MAX_CLICK;
            r_cfg.long_press_ms      <= RST_LONG_PRESS;
            r_cfg.on_timeout_ms      <= RST_ON_TMO;
            r_cfg.pending_timeout_ms <= RST_PEND_TMO;
            r_cfg.halting_timeout_ms <= RST_HALT_TMO;
            r_cfg.alive_pin_used     <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== src/hpbs_step.sv =====
// Sequencer state and per-item update logic: host mode, press timer, silence timer.
// Depends on hpbs_pkg.
module hpbs_step
    import hpbs_pkg::*;
#(
    parameter int TIME_BITS = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [1:0] i_req_type,
    input  logic       i_alive_level,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

    t_mode                r_mode;
    t_mode                n_mode;
    logic                 r_armed;
    logic                 n_armed;
    logic [TIME_BITS-1:0] r_press;
    logic [TIME_BITS-1:0] n_press;
    logic [TIME_BITS-1:0] r_sil;
    logic [TIME_BITS-1:0] n_sil;

    logic [TIME_BITS-1:0] sil_inc;
    logic [TIME_BITS-1:0] press_inc;
    logic [CFG_W-1:0]     limit;
    logic [1:0]           cls;
    logic [1:0]           pulse;
    logic                 shut;
    logic                 sleep;

    // Saturating increments
    assign sil_inc   = (&r_sil)   ? r_sil   : r_sil + 1'b1;
    assign press_inc = (&r_press) ? r_press : r_press + 1'b1;

    always_comb begin
        case (r_mode)
            MODE_PENDING: limit = i_cfg.pending_timeout_ms;
            MODE_HALTING: limit = i_cfg.halting_timeout_ms;
            default:      limit = i_cfg.on_timeout_ms;
        endcase
    end

    // Long press wins over click
    always_comb begin
        if (CMP_W'(r_press) >= CMP_W'(i_cfg.long_press_ms)) begin
            cls = PRESS_LONG;
        end else if (CMP_W'(r_press) >= CMP_W'(i_cfg.min_click_ms) &&
                     CMP_W'(r_press) <= CMP_W'(i_cfg.max_click_ms)) begin
            cls = PRESS_CLICK;
        end else begin
            cls = PRESS_IGNORED;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_armed = r_armed;
        n_press = r_press;
        n_sil   = r_sil;
        pulse   = PULSE_NONE;
        shut    = 1'b0;
        sleep   = 1'b0;
        o_result.press_class = PRESS_NONE;
        case (i_req_type)
            REQ_TICK: begin
                n_sil = sil_inc;
                if (r_armed) begin
                    n_press = press_inc;
                end
                if (r_mode != MODE_OFF) begin
                    if (i_cfg.alive_pin_used && !i_alive_level) begin
                        n_mode = MODE_OFF;
                        sleep  = 1'b1;
                    end else if (CMP_W'(sil_inc) > CMP_W'(limit)) begin
                        n_mode = MODE_OFF;
                        sleep  = 1'b1;
                    end
                end
            end
            REQ_EDGE: begin
                if (!r_armed) begin
                    n_armed = 1'b1;
                    n_press = '0;
                end else begin
                    n_armed = 1'b0;
                    o_result.press_class = cls;
                    // Button is locked while pending or halting
                    if (!(r_mode inside {MODE_PENDING, MODE_HALTING})) begin
                        if (cls == PRESS_LONG) begin
                            if (r_mode == MODE_ON) begin
                                pulse = PULSE_RESET;
                            end
                        end else if (cls == PRESS_CLICK) begin
                            if (r_mode == MODE_ON) begin
                                n_mode = MODE_PENDING;
                                shut   = 1'b1;
                            end else begin
                                pulse  = PULSE_WAKE;
                                n_mode = MODE_ON;
                                n_sil  = '0;
                            end
                        end
                    end
                end
            end
            REQ_HEARTBEAT: begin
                n_sil = '0;
            end
            REQ_HALT: begin
                n_sil  = '0;
                n_mode = MODE_HALTING;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
        o_result.host_state    = mode_code(n_mode);
        o_result.pulse_action  = pulse;
        o_result.shutdown_msg  = shut;
        o_result.sleep_request = sleep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_OFF;
            r_armed <= 1'b0;
            r_press <= '0;
            r_sil   <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_armed <= n_armed;
            r_press <= n_press;
            r_sil   <= n_sil;
        end
    end

endmodule

// ===== src/host_power_button_sequencer.sv =====
// Host power button sequencer: input register, update logic and result register.
// Depends on hpbs_pkg, hpbs_cfg and hpbs_step.
//
// Usage:
//   Input channel: i_in_valid with o_in_stall; a transfer carries a request kind
//   (tick, button edge, heartbeat, halt) and the sampled alive pin level.
//   Output channel: o_out_valid with i_out_stall; each input transfer yields
//   exactly one result transfer: host state, pulse request, shutdown message,
//   sleep request and press class, in input order.
//   Config channel: i_cfg_valid with o_cfg_ready (always high); write only while
//   nothing is in flight.
//   Path: an input transfer is captured in the input register; the update logic
//   then computes its result, which is captured in the result register.
//   Throughput: one item per cycle unless the receiver stalls; the input register,
//   the state update and the result register each handle one item per clock.
//   Stall: when the receiver stalls, the result register holds its value and
//   the input register may still take one more item; after that o_in_stall
//   rises until the result is taken.
//   Reset (synchronous, active low): host assumed off, press pair disarmed,
//   timers cleared, configuration back to its defaults, both registers empty.
module host_power_button_sequencer
    import hpbs_pkg::*;
#(
    parameter int TIME_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_req_type,
    input  logic                 i_alive_level,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_host_state,
    output logic [1:0]           o_pulse_action,
    output logic                 o_shutdown_msg,
    output logic                 o_sleep_request,
    output logic [1:0]           o_press_class,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg       cfg;
    t_result    step_res;

    logic       r_in_valid;
    logic [1:0] r_req_type;
    logic       r_alive_level;
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       advance;
    logic       in_take;

    // Result register frees up when empty or being read this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    hpbs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // State advances only when the held item moves into the result register
    hpbs_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (advance),
        .i_req_type    (r_req_type),
        .i_alive_level (r_alive_level),
        .i_cfg         (cfg),
        .o_result      (step_res)
    );

    // Input register: load on transfer, drop once handed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req_type    <= i_req_type;
            r_alive_level <= i_alive_level;
        end
    end

    // Result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_host_state    = r_out.host_state;
    assign o_pulse_action  = r_out.pulse_action;
    assign o_shutdown_msg  = r_out.shutdown_msg;
    assign o_sleep_request = r_out.sleep_request;
    assign o_press_class   = r_out.press_class;

endmodule

// ===== src/hpbs_checker.sv =====
// Port-level checker for the host power button sequencer, bound to the top level.
// Depends on hpbs_pkg and host_power_button_sequencer_defines.svh.
`include "host_power_button_sequencer_defines.svh"

module hpbs_checker
    import hpbs_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_host_state,
    input logic [1:0] o_pulse_action,
    input logic       o_shutdown_msg,
    input logic       o_sleep_request,
    input logic [1:0] o_press_class
);

    // A stalled result keeps its host state, pulse request and press class
    `HPBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_host_state) && $stable(o_pulse_action) &&
        $stable(o_press_class))

    // Sleep only with the host forced off and no other request
    `HPBS_ASSERT_NOW(a_sleep_off, i_clk, i_rst_n, o_out_valid && o_sleep_request,
        o_host_state == HOST_OFF && o_pulse_action == PULSE_NONE && !o_shutdown_msg &&
        o_press_class == PRESS_NONE)

    // Wake pulse comes from a click and leaves the host on
    `HPBS_ASSERT_NOW(a_wake_click, i_clk, i_rst_n, o_out_valid && o_pulse_action == PULSE_WAKE,
        o_host_state == HOST_ON && o_press_class == PRESS_CLICK)

    // Shutdown message comes from a click and leaves shutdown pending
    `HPBS_ASSERT_NOW(a_shut_click, i_clk, i_rst_n, o_out_valid && o_shutdown_msg,
        o_host_state == HOST_PENDING && o_press_class == PRESS_CLICK &&
        o_pulse_action == PULSE_NONE)

    // Reset empties the result register
    `HPBS_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind host_power_button_sequencer hpbs_checker u_hpbs_checker (.*);

// ===== tb/hpbs_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the host power button sequencer: mirrors config writes, predicts
// one result per input transfer and compares result transfers in order. Depends on hpbs_pkg.
module hpbs_result_checker
    import hpbs_pkg::*;
#(
    parameter int TIME_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [1:0]           i_req_type,
    input  logic                 i_alive_level,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [1:0]           i_host_state,
    input  logic [1:0]           i_pulse_action,
    input  logic                 i_shutdown_msg,
    input  logic                 i_sleep_request,
    input  logic [1:0]           i_press_class,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_outstanding,
    output int                   o_mismatches
);

    localparam logic [TIME_BITS-1:0] TIME_SAT = '1;

    t_cfg                 cfg;
    logic [1:0]           host_mode;
    logic                 press_armed;
    logic [TIME_BITS-1:0] press_ms;
    logic [TIME_BITS-1:0] silence_ms;
    t_result              expected_q[$];
    int                   mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
        return (v == TIME_SAT) ? v : v + 1'b1;
    endfunction

    // Advance the mirrored host state by one request and return the result it yields.
    function automatic t_result advance_host(input logic [1:0] kind, input logic alive);
        t_result          r;
        logic [CFG_W-1:0] limit;
        r.host_state    = HOST_OFF;
        r.pulse_action  = PULSE_NONE;
        r.shutdown_msg  = 1'b0;
        r.sleep_request = 1'b0;
        r.press_class   = PRESS_NONE;
        case (kind)
            REQ_TICK: begin
                silence_ms = sat_inc(silence_ms);
                if (press_armed)
                    press_ms = sat_inc(press_ms);
                if (host_mode != HOST_OFF) begin
                    limit = (host_mode == HOST_PENDING) ? cfg.pending_timeout_ms :
                            (host_mode == HOST_HALTING) ? cfg.halting_timeout_ms :
                                                          cfg.on_timeout_ms;
                    // a dead host and a silent host end the same way
                    if ((cfg.alive_pin_used && !alive) || silence_ms > limit) begin
                        host_mode       = HOST_OFF;
                        r.sleep_request = 1'b1;
                    end
                end
            end
            REQ_EDGE: begin
                if (!press_armed) begin
                    press_armed = 1'b1;
                    press_ms    = '0;
                end else begin
                    press_armed = 1'b0;
                    if (press_ms >= cfg.long_press_ms)
                        r.press_class = PRESS_LONG;
                    else if (press_ms >= cfg.min_click_ms && press_ms <= cfg.max_click_ms)
                        r.press_class = PRESS_CLICK;
                    else
                        r.press_class = PRESS_IGNORED;
                    if (host_mode == HOST_ON) begin
                        if (r.press_class == PRESS_LONG) begin
                            r.pulse_action = PULSE_RESET;
                        end else if (r.press_class == PRESS_CLICK) begin
                            host_mode      = HOST_PENDING;
                            r.shutdown_msg = 1'b1;
                        end
                    end else if (host_mode == HOST_OFF && r.press_class == PRESS_CLICK) begin
                        r.pulse_action = PULSE_WAKE;
                        host_mode      = HOST_ON;
                        silence_ms     = '0;
                    end
                end
            end
            REQ_HEARTBEAT: begin
                silence_ms = '0;
            end
            REQ_HALT: begin
                silence_ms = '0;
                host_mode  = HOST_HALTING;
            end
        endcase
        r.host_state = host_mode;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        mismatch_total++;
        if (mismatch_total <= 10) begin
            $write("%0t: %s: expected state=%0d pulse=%0d shut=%0b sleep=%0b class=%0d, ",
                   $time, what, want.host_state, want.pulse_action, want.shutdown_msg,
                   want.sleep_request, want.press_class);
            $display("got state=%0d pulse=%0d shut=%0b sleep=%0b class=%0d",
                     got.host_state, got.pulse_action, got.shutdown_msg,
                     got.sleep_request, got.press_class);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg         = '{RST_MIN_CLICK, RST_MAX_CLICK, RST_LONG_PRESS, RST_ON_TMO,
                            RST_PEND_TMO, RST_HALT_TMO, 1'b0};
            host_mode   = HOST_OFF;
            press_armed = 1'b0;
            press_ms    = '0;
            silence_ms  = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIN_CLICK:  cfg.min_click_ms       = i_cfg_data;
                    CFG_MAX_CLICK:  cfg.max_click_ms       = i_cfg_data;
                    CFG_LONG_PRESS: cfg.long_press_ms      = i_cfg_data;
                    CFG_ON_TMO:     cfg.on_timeout_ms      = i_cfg_data;
                    CFG_PEND_TMO:   cfg.pending_timeout_ms = i_cfg_data;
                    CFG_HALT_TMO:   cfg.halting_timeout_ms = i_cfg_data;
                    CFG_ALIVE_USED: cfg.alive_pin_used     = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(advance_host(i_req_type, i_alive_level));
            if (i_out_valid && !i_out_stall) begin
                got = {i_host_state, i_pulse_action, i_shutdown_msg, i_sleep_request,
                       i_press_class};
                if (expected_q.size() == 0) begin
                    note_mismatch("result transfer with nothing expected", '0, got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want)
                        note_mismatch("result mismatch", want, got);
                end
            end
        end
        o_outstanding <= expected_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the host power button sequencer regression: clock, reset, stimulus and verdict.
// Depends on hpbs_pkg, host_power_button_sequencer and hpbs_result_checker.
module testbench
    import hpbs_pkg::*;
();

    localparam int TIME_BITS = 20;
    // index past the last register; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic [1:0]           i_req_type    = REQ_TICK;
    logic                 i_alive_level = 1'b1;
    logic                 i_out_stall   = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_MIN_CLICK;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [1:0]           o_host_state;
    logic [1:0]           o_pulse_action;
    logic                 o_shutdown_msg;
    logic                 o_sleep_request;
    logic [1:0]           o_press_class;
    logic                 o_cfg_ready;

    int   outstanding;
    int   mismatches;

    logic gaps_on    = 1'b0;  // random idling on both channels
    int   stall_left = 0;
    int   items_sent = 0;
    bit   pair_open  = 1'b0;  // an odd number of button edges went in so far
    t_cfg plan_cfg;           // thresholds now in force, used to aim press lengths

    host_power_button_sequencer #(
        .TIME_BITS(TIME_BITS)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_alive_level     (i_alive_level),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_host_state      (o_host_state),
        .o_pulse_action    (o_pulse_action),
        .o_shutdown_msg    (o_shutdown_msg),
        .o_sleep_request   (o_sleep_request),
        .o_press_class     (o_press_class),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    hpbs_result_checker #(
        .TIME_BITS(TIME_BITS)
    ) result_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_alive_level     (i_alive_level),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_host_state      (o_host_state),
        .i_pulse_action    (o_pulse_action),
        .i_shutdown_msg    (o_shutdown_msg),
        .i_sleep_request   (o_sleep_request),
        .i_press_class     (o_press_class),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_outstanding     (outstanding),
        .o_mismatches      (mismatches)
    );

    // 250 MHz clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop: about 800 items, with idling and stalls, need well under a tenth of this.
    initial begin
        #2_000_000;
        $display("host_power_button_sequencer regression: fail");
        $finish;
    end

    // Receiver side: stall in random bursts while idling is on.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 7);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Mostly alive; a low level now and then drops the host once the check is enabled.
    function automatic logic alive_draw();
        return $urandom_range(0, 15) != 0;
    endfunction

    // Drive one request and hold it until the transfer happens.
    task automatic send_item(input logic [1:0] kind, input logic alive);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= kind;
        i_alive_level <= alive;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        if (kind == REQ_EDGE)
            pair_open = !pair_open;
    endtask

    // Drop valid and wait until every result is back, then let the pipe settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Write all registers back to back while the block is idle.
    task automatic load_config(input t_cfg c, input bit poke_unused);
        drain();
        write_reg(CFG_MIN_CLICK,  c.min_click_ms);
        write_reg(CFG_MAX_CLICK,  c.max_click_ms);
        write_reg(CFG_LONG_PRESS, c.long_press_ms);
        write_reg(CFG_ON_TMO,     c.on_timeout_ms);
        write_reg(CFG_PEND_TMO,   c.pending_timeout_ms);
        write_reg(CFG_HALT_TMO,   c.halting_timeout_ms);
        // upper data bits are don't-care for the one-bit register
        write_reg(CFG_ALIVE_USED, {19'($urandom), c.alive_pin_used});
        if (poke_unused)
            write_reg(CFG_NO_REG, 20'($urandom));
        i_cfg_valid <= 1'b0;
        plan_cfg = c;
    endtask

    // Pick a press length, mostly near one of the class boundaries, kept short.
    function automatic int pick_hold();
        int lo     = plan_cfg.min_click_ms;
        int hi     = plan_cfg.max_click_ms;
        int longer = plan_cfg.long_press_ms;
        int h;
        case ($urandom_range(0, 7))
            0:       h = lo - 1;
            1:       h = lo;
            2:       h = lo + 1;
            3:       h = hi;
            4:       h = hi + 1;
            5:       h = longer - 1;
            6:       h = longer;
            default: h = $urandom_range(0, 24);
        endcase
        if (h < 0 || h > 40)
            h = $urandom_range(0, 40);
        return h;
    endfunction

    // One full press: close any half-open pair first, then edge, ticks, edge.
    task automatic press_button(input int hold_ms);
        if (pair_open)
            send_item(REQ_EDGE, 1'($urandom_range(0, 1)));
        send_item(REQ_EDGE, 1'($urandom_range(0, 1)));
        repeat (hold_ms) begin
            if ($urandom_range(0, 5) == 0)
                send_item(REQ_HEARTBEAT, 1'($urandom_range(0, 1)));
            send_item(REQ_TICK, alive_draw());
        end
        send_item(REQ_EDGE, 1'($urandom_range(0, 1)));
    endtask

    // Mostly well-formed activity (presses, quiet time, halts) with some raw noise.
    task automatic run_random(input int count);
        int goal;
        int pick;
        bit beating;
        goal = items_sent + count;
        while (items_sent < goal) begin
            gaps_on <= ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick <= 4) begin
                press_button(pick_hold());
            end else if (pick <= 6) begin
                // quiet stretch: with no heartbeat the host times out
                beating = $urandom_range(0, 1);
                repeat ($urandom_range(1, 30)) begin
                    if (beating && $urandom_range(0, 7) == 0)
                        send_item(REQ_HEARTBEAT, 1'($urandom_range(0, 1)));
                    send_item(REQ_TICK, alive_draw());
                end
            end else if (pick == 7) begin
                send_item(REQ_HALT, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 8)) send_item(REQ_TICK, alive_draw());
            end else begin
                repeat ($urandom_range(1, 3))
                    send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        plan_cfg = '{RST_MIN_CLICK, RST_MAX_CLICK, RST_LONG_PRESS, RST_ON_TMO,
                     RST_PEND_TMO, RST_HALT_TMO, 1'b0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: short requests only; a zero-length press is ignored,
        // a halt line moves even an off host to halting, the alive pin is unused.
        send_item(REQ_TICK,      1'b1);
        send_item(REQ_HEARTBEAT, 1'b0);
        send_item(REQ_EDGE,      1'b1);
        send_item(REQ_EDGE,      1'b0);
        send_item(REQ_HALT,      1'b0);
        send_item(REQ_TICK,      1'b0);
        send_item(REQ_HEARTBEAT, 1'b1);
        send_item(REQ_TICK,      1'b1);
        run_random(40);

        // Small thresholds: wake from off, shutdown request from on, press locked
        // while pending, halt line, alive level still ignored.
        load_config('{20'd2, 20'd5, 20'd8, 20'd20, 20'd12, 20'd6, 1'b0}, 1'b0);
        press_button(3);
        press_button(2);
        press_button(0);
        send_item(REQ_HEARTBEAT, 1'b0);
        send_item(REQ_HALT,      1'b1);
        send_item(REQ_TICK,      1'b0);
        run_random(220);

        // All zero: every press is long, any tick outside off times out.
        load_config('{20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 1'b1}, 1'b0);
        run_random(120);

        // All ones: nearly every press is a click, only the alive pin drops the host.
        load_config('{20'd0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b1},
                    1'b1);
        run_random(180);

        // Empty click window: a press is long or ignored.
        load_config('{20'd5, 20'd3, 20'd6, 20'd10, 20'd25, 20'd4, 1'b1}, 1'b0);
        run_random(200);

        // Last part, no idling: a low alive level drops a halting host, a click wakes
        // it, it stays on without heartbeat under the top limit, then an ignored
        // press and a click that asks for shutdown.
        gaps_on <= 1'b0;
        load_config('{20'd1, 20'd3, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b1}, 1'b0);
        send_item(REQ_HALT, 1'b1);
        send_item(REQ_TICK, 1'b0);
        press_button(2);
        repeat (20) send_item(REQ_TICK, 1'b1);
        press_button(6);
        press_button(1);
        send_item(REQ_TICK, 1'b1);

        drain();
        if (mismatches == 0)
            $display("host_power_button_sequencer regression: pass");
        else
            $display("host_power_button_sequencer regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/hpbs_pkg.sv
src/hpbs_cfg.sv
src/hpbs_step.sv
src/host_power_button_sequencer.sv
src/hpbs_checker.sv
tb/hpbs_result_checker.sv
tb/testbench.sv
